>>> hdl/otvgt_pkg.sv
package otvgt_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 16;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 112;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_EPOCH = 3'd1,
    ST_REGRESSED = 3'd2,
    ST_BAD_TAG   = 3'd3,
    ST_BAD_LINK  = 3'd4,
    ST_DEANON    = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_AUTH  = 2'd1
  } kind_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_end;
  } sts_t;

endpackage

>>> hdl/otvgt_ctrl.sv
module otvgt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  otvgt_pkg::sts_t sts,
  output otvgt_pkg::cmd_t cmd
);
  import otvgt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = sts.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hdl/otvgt_dp.sv
module otvgt_dp #(
  parameter int unsigned TABLE_ENTRIES = otvgt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [otvgt_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  otvgt_pkg::cmd_t                   cmd,
  output otvgt_pkg::sts_t                   sts,
  output logic [otvgt_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import otvgt_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  logic [31:0] tag_mem  [TABLE_ENTRIES];
  logic        mode_mem [TABLE_ENTRIES];

  logic                     kind_r;
  logic [31:0]              ep_r;
  logic [31:0]              tag_r;
  logic [1:0]               link_r;
  logic [31:0]              epoch_r, epoch_nxt;
  logic [TABLE_ENTRIES-1:0] used_r, used_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [IW-1:0]            idx_r;
  logic [IW-1:0]            rd_idx_r;
  logic                     rd_valid_r;
  logic [31:0]              rd_tag_r;
  logic                     rd_mode_r;
  logic                     found_r;
  logic                     found_mode_r;
  logic                     free_found_r;
  logic [IW-1:0]            free_idx_r;
  logic [OUT_DATA_W-1:0]    out_r;

  logic        hit_now;
  logic        do_write;
  status_t     status;
  logic [31:0] g_epoch;
  logic [31:0] g_tag;
  logic        g_link;
  logic        g_linked;
  logic        present;
  logic [4:0]  count_ext;

  assign hit_now = rd_valid_r && used_r[rd_idx_r] && (rd_tag_r == tag_r);

  assign sts.need_scan = kind_r && (epoch_r != 32'd0) && (tag_r != 32'd0) && !link_r[1];
  assign sts.scan_end  = rd_valid_r && (hit_now || (rd_idx_r == LAST_IDX));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_tuser;
      ep_r   <= in_tdata[31:0];
      tag_r  <= in_tdata[63:32];
      link_r <= in_tdata[65:64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      rd_valid_r   <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.latch) begin
      idx_r        <= '0;
      rd_valid_r   <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.step) begin
      rd_valid_r <= 1'b1;
      if (idx_r != LAST_IDX) begin
        idx_r <= idx_r + 1'b1;
      end
      if (hit_now) begin
        found_r <= 1'b1;
      end
      if (rd_valid_r && !free_found_r && !used_r[rd_idx_r]) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_tag_r  <= tag_mem[idx_r];
      rd_mode_r <= mode_mem[idx_r];
      rd_idx_r  <= idx_r;
      if (hit_now) begin
        found_mode_r <= rd_mode_r;
      end
      if (rd_valid_r && !free_found_r && !used_r[rd_idx_r]) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  always_comb begin
    status    = ST_OK;
    g_epoch   = '0;
    g_tag     = '0;
    g_link    = 1'b0;
    g_linked  = 1'b0;
    present   = 1'b0;
    do_write  = 1'b0;
    epoch_nxt = epoch_r;
    used_nxt  = used_r;
    count_nxt = count_r;
    if (kind_r == KIND_BEGIN[0]) begin
      if (ep_r == 32'd0) begin
        status = ST_BAD_EPOCH;
      end else if (ep_r <= epoch_r) begin
        status = ST_REGRESSED;
      end else begin
        epoch_nxt = ep_r;
        used_nxt  = '0;
        count_nxt = '0;
      end
    end else if (epoch_r == 32'd0) begin
      status = ST_BAD_EPOCH;
    end else if (tag_r == 32'd0) begin
      status = ST_BAD_TAG;
    end else if (link_r[1]) begin
      status = ST_BAD_LINK;
    end else if (found_r) begin
      present = 1'b1;
      if (!link_r[0] || !found_mode_r) begin
        status = ST_DEANON;
      end else begin
        g_epoch  = epoch_r;
        g_tag    = tag_r;
        g_link   = link_r[0];
        g_linked = 1'b1;
      end
    end else if (!free_found_r) begin
      status = ST_FULL;
    end else begin
      do_write             = 1'b1;
      used_nxt[free_idx_r] = 1'b1;
      count_nxt            = count_r + 1'b1;
      g_epoch              = epoch_r;
      g_tag                = tag_r;
      g_link               = link_r[0];
      g_linked             = link_r[0];
    end
  end

  assign count_ext = 5'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= '0;
      used_r  <= '0;
      count_r <= '0;
    end else if (cmd.commit) begin
      epoch_r <= epoch_nxt;
      used_r  <= used_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) begin
      tag_mem[free_idx_r]  <= tag_r;
      mode_mem[free_idx_r] <= link_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= {5'd0, count_ext, epoch_nxt, present, g_linked, g_link,
                g_tag, g_epoch, status};
    end
  end

  assign out_tdata = out_r;

endmodule

>>> hdl/one_time_verifier_grant_table.sv
// One-time verifier grant table.
//
// Items arrive on the in_ stream: in_tuser is the kind (begin epoch or
// authorise), in_tdata carries epoch, tag and linkage mode. Each accepted item
// yields exactly one result on the out_ stream, carrying the status, the grant
// fields, the current epoch and the number of occupied entries.
//
// The block works on one item at a time. A begin item, or an authorise item
// refused before the lookup, goes from the decide state to the done state.
// Other authorise items search the tag memory one entry per cycle through
// its single registered read port; a hit ends the search early.
//
// The result sits in an output register. The next item is accepted while it
// waits; a stalled receiver holds the block only when that next result is
// ready to be loaded. Synchronous reset clears the epoch, the occupancy bits
// and the count; the table needs no clearing pass.
module one_time_verifier_grant_table #(
  parameter int unsigned TABLE_ENTRIES = otvgt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // epoch_value[31:0], verifier_tag[63:32], linkage_mode[65:64], zero pad
  input  logic [otvgt_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[2:0], grant_epoch[34:3], grant_verifier[66:35], grant_linkage[67],
  // grant_linked[68], tag_was_present[69], epoch_now[101:70],
  // attested_count[106:102], zero pad
  output logic [otvgt_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import otvgt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  otvgt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  otvgt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

>>> hdl/otvgt_chk.sv
module otvgt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [otvgt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import otvgt_pkg::*;

  logic [2:0] st;
  assign st = out_tdata[2:0];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before its transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_refused_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st != ST_OK) |-> (out_tdata[68:3] == '0))
    else $error("grant fields set on a refused item");

  a_deanon_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_DEANON) |-> out_tdata[69])
    else $error("refusal for linkage without the tag being present");

  a_grant_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_OK) && (out_tdata[66:35] != 32'd0)
      |-> (out_tdata[34:3] == out_tdata[101:70]))
    else $error("grant epoch differs from current epoch");

endmodule

bind one_time_verifier_grant_table otvgt_chk u_otvgt_chk (.*);
